[src/gclcv_pkg.sv]
// Shared types, register codes and fixed constants for the growth-curve length and CV block.
package gclcv_pkg;

	typedef struct packed {
		logic [7:0]  age_class;
		logic [15:0] step_fraction;
	} gclcv_query_t;

	typedef struct packed {
		logic [31:0] length_at_age;
		logic [31:0] cv_at_age;
		logic        exponent_too_large;
		logic        age_out_of_range;
		logic        span_is_zero;
	} gclcv_result_t;

	typedef enum logic [2:0] {
		REG_LINF      = 3'd0,
		REG_GROWTH    = 3'd1,
		REG_T0        = 3'd2,
		REG_FIRST_CV  = 3'd3,
		REG_LAST_CV   = 3'd4,
		REG_BY_LENGTH = 3'd5,
		REG_YOUNGEST  = 3'd6,
		REG_OLDEST    = 3'd7
	} gclcv_reg_t;

	// Sideband that rides along with the CV division.
	typedef struct packed {
		logic [31:0] len;
		logic        big;
		logic        oor;
		logic        spanz;
		logic        use_first;
		logic        neg;
	} gclcv_side_t;

	localparam int TAYLOR_TERMS = 10;
	localparam int POWER_STAGES = 31;
	localparam int EXP_LAT      = 1 + 2 * TAYLOR_TERMS + POWER_STAGES;
	localparam int LANE_LAT     = 3 + EXP_LAT + 1;
	localparam int DIV_STAGES   = 64;
	localparam int TOTAL_LAT    = LANE_LAT + 2 + DIV_STAGES + 1;

	localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
	localparam logic [30:0] EXP_M1_Q32 = 31'd1580030169;

	// ceil(2^36 / n) for n = 10 down to 1; exact quotients for 32-bit dividends.
	localparam logic [36:0] RECIP_Q36 [TAYLOR_TERMS] = '{
		37'd6871947674, 37'd7635497416, 37'd8589934592, 37'd9817068106,
		37'd11453246123, 37'd13743895348, 37'd17179869184, 37'd22906492246,
		37'd34359738368, 37'd68719476736
	};

endpackage

[src/gclcv_exp.sv]
// Pipelined exp(-m) in Q1.32: Taylor steps in Horner form, then powers of exp(-1).
module gclcv_exp import gclcv_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] m,
	output logic        out_valid,
	output logic [32:0] e
);

	localparam int FW2 = 2 * FRAC_BITS;

	typedef struct packed {
		logic        ovf;
		logic [4:0]  ip;
		logic [31:0] f;
	} hside_t;

	logic [31:0] f32;
	logic        v1_s;
	hside_t      h1_s;

	logic [TAYLOR_TERMS-1:0] ta_v_s, tb_v_s;
	hside_t      ta_h_s [TAYLOR_TERMS];
	hside_t      tb_h_s [TAYLOR_TERMS];
	logic [31:0] ta_t_s [TAYLOR_TERMS];
	logic [32:0] tb_p_s [TAYLOR_TERMS];

	logic [POWER_STAGES-1:0] pw_v_s;
	hside_t      pw_h_s [POWER_STAGES];
	logic [32:0] pw_p_s [POWER_STAGES];

	logic [TAYLOR_TERMS-1:0] hv_in;
	hside_t      hh_in  [TAYLOR_TERMS];
	logic [32:0] hp_in  [TAYLOR_TERMS];
	logic [31:0] ta_t_d [TAYLOR_TERMS];
	logic [32:0] tb_p_d [TAYLOR_TERMS];
	logic [POWER_STAGES-1:0] pv_in;
	hside_t      ph_in  [POWER_STAGES];
	logic [32:0] pp_in  [POWER_STAGES];
	logic [32:0] pw_p_d [POWER_STAGES];
	logic [64:0] hprod;
	logic [68:0] est;
	logic [63:0] pprod;

	generate
		if (FW2 >= 32) begin : g_f_cut
			assign f32 = m[FW2-1 -: 32];
		end else begin : g_f_pad
			assign f32 = {m[FW2-1:0], {(32 - FW2){1'b0}}};
		end
	endgenerate

	always_comb begin
		hv_in[0] = v1_s;
		hh_in[0] = h1_s;
		hp_in[0] = ONE_Q32;
		for (int j = 1; j < TAYLOR_TERMS; j++) begin
			hv_in[j] = tb_v_s[j-1];
			hh_in[j] = tb_h_s[j-1];
			hp_in[j] = tb_p_s[j-1];
		end
		for (int j = 0; j < TAYLOR_TERMS; j++) begin
			hprod     = hh_in[j].f * hp_in[j];
			ta_t_d[j] = hprod[63:32];
			est       = ta_t_s[j] * RECIP_Q36[j];
			tb_p_d[j] = ONE_Q32 - {1'b0, est[67:36]};
		end
		pv_in[0] = tb_v_s[TAYLOR_TERMS-1];
		ph_in[0] = tb_h_s[TAYLOR_TERMS-1];
		pp_in[0] = tb_p_s[TAYLOR_TERMS-1];
		for (int i = 1; i < POWER_STAGES; i++) begin
			pv_in[i] = pw_v_s[i-1];
			ph_in[i] = pw_h_s[i-1];
			pp_in[i] = pw_p_s[i-1];
		end
		for (int i = 0; i < POWER_STAGES; i++) begin
			pprod     = pp_in[i] * EXP_M1_Q32;
			pw_p_d[i] = (ph_in[i].ip > 5'(i)) ? {1'b0, pprod[63:32]} : pp_in[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s   <= 1'b0;
			ta_v_s <= '0;
			tb_v_s <= '0;
			pw_v_s <= '0;
		end else begin
			v1_s   <= in_valid;
			ta_v_s <= hv_in;
			tb_v_s <= ta_v_s;
			pw_v_s <= pv_in;
		end
	end

	always_ff @(posedge clk) begin
		h1_s.ovf <= |m[63:FW2+5];
		h1_s.ip  <= m[FW2+4:FW2];
		h1_s.f   <= f32;
		for (int j = 0; j < TAYLOR_TERMS; j++) begin
			ta_h_s[j] <= hh_in[j];
			ta_t_s[j] <= ta_t_d[j];
			tb_h_s[j] <= ta_h_s[j];
			tb_p_s[j] <= tb_p_d[j];
		end
		for (int i = 0; i < POWER_STAGES; i++) begin
			pw_h_s[i] <= ph_in[i];
			pw_p_s[i] <= pw_p_d[i];
		end
	end

	assign out_valid = pw_v_s[POWER_STAGES-1];
	assign e = pw_h_s[POWER_STAGES-1].ovf ? '0 : pw_p_s[POWER_STAGES-1];

endmodule

[src/gclcv_lane.sv]
// One mean-length lane: exponent argument, saturated product, exp and final scaling.
module gclcv_lane import gclcv_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           age,
	input  logic [FRAC_BITS-1:0] frac,
	input  logic [31:0]          linf,
	input  logic [31:0]          k,
	input  logic signed [31:0]   t0,
	output logic                 out_valid,
	output logic [31:0]          len,
	output logic                 big
);

	localparam int XW = ((9 + FRAC_BITS) > 33 ? (9 + FRAC_BITS) : 33) + 1;
	localparam int MW = XW - 1;
	localparam int PW = 32 + MW;
	localparam logic [63:0] TEN_Q = 64'd10 << (2 * FRAC_BITS);

	logic signed [XW-1:0] x;
	logic [XW-1:0] xabs;
	logic [PW-1:0] full;
	logic [63:0]   m_sat;

	logic          v_s1, v_s2, v_s3, v_s4;
	logic          neg_s1, neg_s2;
	logic [MW-1:0] mag_s1;
	logic [63:0]   plo_s2;
	logic [MW-1:0] phi_s2;
	logic          big_s3;
	logic [63:0]   m_s3;
	logic [EXP_LAT-1:0] bd_s;
	logic [31:0]   len_s4;
	logic          big_s4;

	logic          e_valid;
	logic [32:0]   e_val;
	logic [32:0]   one_minus;
	logic [64:0]   lprod;

	always_comb begin
		x = $signed({{(XW - 8 - FRAC_BITS){1'b0}}, age, {FRAC_BITS{1'b0}}})
			+ $signed({{(XW - FRAC_BITS){1'b0}}, frac})
			- $signed({{(XW - 32){t0[31]}}, t0});
		xabs  = x[XW-1] ? XW'(-x) : XW'(x);
		full  = {phi_s2, 32'd0} + {{(PW - 64){1'b0}}, plo_s2};
		m_sat = (|full[PW-1:64]) ? '1 : full[63:0];
		one_minus = ONE_Q32 - e_val;
		lprod     = linf * one_minus;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= e_valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= x[XW-1];
		mag_s1 <= xabs[MW-1:0];
		neg_s2 <= neg_s1;
		plo_s2 <= k * mag_s1[31:0];
		phi_s2 <= k * mag_s1[MW-1:32];
		// A negative argument means the length is zero: feed exp a zero argument.
		big_s3 <= neg_s2 && (m_sat > TEN_Q);
		m_s3   <= neg_s2 ? '0 : m_sat;
		bd_s   <= {bd_s[EXP_LAT-2:0], big_s3};
		len_s4 <= lprod[63:32];
		big_s4 <= bd_s[EXP_LAT-1];
	end

	gclcv_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.m         (m_s3),
		.out_valid (e_valid),
		.e         (e_val)
	);

	assign out_valid = v_s4;
	assign len       = len_s4;
	assign big       = big_s4;

endmodule

[src/gclcv_div.sv]
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per stage.
module gclcv_div import gclcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	input  gclcv_side_t in_side,
	output logic        out_valid,
	output logic [63:0] quotient,
	output gclcv_side_t out_side
);

	logic [DIV_STAGES-1:0] v_s;
	logic [63:0]  dq_s  [DIV_STAGES];
	logic [31:0]  rem_s [DIV_STAGES];
	logic [31:0]  dv_s  [DIV_STAGES];
	gclcv_side_t  sd_s  [DIV_STAGES];

	logic [DIV_STAGES-1:0] v_in;
	logic [63:0]  dq_in  [DIV_STAGES];
	logic [31:0]  rem_in [DIV_STAGES];
	logic [31:0]  dv_in  [DIV_STAGES];
	gclcv_side_t  sd_in  [DIV_STAGES];
	logic [63:0]  dq_d   [DIV_STAGES];
	logic [31:0]  rem_d  [DIV_STAGES];
	logic [32:0]  r2;
	logic         ge;

	always_comb begin
		v_in[0]   = in_valid;
		dq_in[0]  = dividend;
		rem_in[0] = '0;
		dv_in[0]  = divisor;
		sd_in[0]  = in_side;
		for (int i = 1; i < DIV_STAGES; i++) begin
			v_in[i]   = v_s[i-1];
			dq_in[i]  = dq_s[i-1];
			rem_in[i] = rem_s[i-1];
			dv_in[i]  = dv_s[i-1];
			sd_in[i]  = sd_s[i-1];
		end
		for (int i = 0; i < DIV_STAGES; i++) begin
			r2       = {rem_in[i], dq_in[i][63]};
			ge       = r2 >= {1'b0, dv_in[i]};
			rem_d[i] = ge ? 32'(r2 - {1'b0, dv_in[i]}) : r2[31:0];
			dq_d[i]  = {dq_in[i][62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			dq_s[i]  <= dq_d[i];
			rem_s[i] <= rem_d[i];
			dv_s[i]  <= dv_in[i];
			sd_s[i]  <= sd_in[i];
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quotient  = dq_s[DIV_STAGES-1];
	assign out_side  = sd_s[DIV_STAGES-1];

endmodule

[src/growth_curve_length_and_cv.sv]
// Top level: growth-curve mean length and CV per age class, fully pipelined.
//
//   channel   ports                            transfer rule
//   -------   ------------------------------   ----------------------------------
//   query     start, busy, query               taken when start=1 and busy=0
//   result    done, result                     one cycle wide strobe, no back-pressure
//   config    cfg_write, cfg_index, cfg_data   written on any edge with cfg_write=1
//
// A new query transaction is taken on every clock; busy is always low.
// A result passes through the length lanes (mostly the 20 Horner and 31 exp(-1)
// power stages), two registers of span setup and product, 64 divider stages
// and one output register.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so the pipeline never holds and nothing is dropped.
module growth_curve_length_and_cv import gclcv_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int AGE_BITS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  gclcv_query_t  query,
	output logic          done,
	output gclcv_result_t result,
	input  logic          cfg_write,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int AW = (AGE_BITS < 8) ? AGE_BITS : 8;
	localparam logic [7:0] AGE_MASK = 8'((1 << AW) - 1);

	typedef struct packed {
		logic [7:0] age;
		logic       oor;
	} tag_t;

	// Configuration registers; the user must write them only while no transaction is in flight (not enforced here).
	logic [31:0]        linf_q, k_q, first_q, last_q;
	logic signed [31:0] t0_q;
	logic               bylen_q;
	logic [7:0]         young_q, old_q;

	logic                 accept;
	logic [7:0]           age_m;
	logic [39:0]          fr_wide;
	logic [FRAC_BITS-1:0] fracf;
	tag_t                 tag_s [LANE_LAT];

	logic        lq_valid, lq_big;
	logic [31:0] lq_len, ly_len, lo_len;

	logic signed [33:0] num, den;
	logic [33:0]  nabs, eabs;
	logic         neg_d;
	logic [31:0]  dmag;
	logic         den_zero;
	gclcv_side_t  side_d;

	logic         v_s1, v_s2;
	logic [31:0]  nmag_s1, emag_s1, dmag_s1, emag_s2;
	gclcv_side_t  side_s1, side_s2;
	logic [63:0]  prod_s2;

	logic         dv_valid;
	logic [63:0]  quot;
	gclcv_side_t  dv_side;
	logic [31:0]  cv_d;

	logic          done_q;
	gclcv_result_t result_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linf_q  <= '0;
			k_q     <= '0;
			t0_q    <= '0;
			first_q <= '0;
			last_q  <= '0;
			bylen_q <= 1'b1;
			young_q <= '0;
			old_q   <= 8'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LINF:      linf_q  <= cfg_data;
				REG_GROWTH:    k_q     <= cfg_data;
				REG_T0:        t0_q    <= cfg_data;
				REG_FIRST_CV:  first_q <= cfg_data;
				REG_LAST_CV:   last_q  <= cfg_data;
				REG_BY_LENGTH: bylen_q <= cfg_data[0];
				REG_YOUNGEST:  young_q <= cfg_data[7:0];
				REG_OLDEST:    old_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The step fraction is moved from Q0.16 to the internal fraction width by
	// taking the top bits of a zero-padded word; this covers both shift directions.
	assign age_m   = query.age_class & AGE_MASK;
	assign fr_wide = {query.step_fraction, 24'd0};
	assign fracf   = fr_wide[39 -: FRAC_BITS];

	// Three lanes run side by side: the queried age and both span end points.
	// The end-point lanes see the same step fraction as the query.
	gclcv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_query (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .age(age_m), .frac(fracf),
		.linf(linf_q), .k(k_q), .t0(t0_q),
		.out_valid(lq_valid), .len(lq_len), .big(lq_big)
	);

	gclcv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_young (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .age(young_q), .frac(fracf),
		.linf(linf_q), .k(k_q), .t0(t0_q),
		.out_valid(), .len(ly_len), .big()
	);

	gclcv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_old (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .age(old_q), .frac(fracf),
		.linf(linf_q), .k(k_q), .t0(t0_q),
		.out_valid(), .len(lo_len), .big()
	);

	// The age and range flag travel alongside the lanes so they line up with
	// the query lane's output.
	always_ff @(posedge clk) begin
		tag_s[0].age <= age_m;
		tag_s[0].oor <= (age_m < young_q) || (age_m > old_q);
		for (int i = 1; i < LANE_LAT; i++) begin
			tag_s[i] <= tag_s[i-1];
		end
	end

	// Span setup: numerator and denominator either by length or by age, then
	// reduced to magnitudes and one sign so the divider works unsigned.
	always_comb begin
		if (bylen_q) begin
			num = $signed({2'b00, lq_len}) - $signed({2'b00, ly_len});
			den = $signed({2'b00, lo_len}) - $signed({2'b00, ly_len});
		end else begin
			num = $signed({26'd0, tag_s[LANE_LAT-1].age}) - $signed({26'd0, young_q});
			den = $signed({26'd0, old_q}) - $signed({26'd0, young_q});
		end
		nabs     = num[33] ? 34'(-num) : 34'(num);
		eabs     = den[33] ? 34'(-den) : 34'(den);
		neg_d    = last_q < first_q;
		dmag     = neg_d ? (first_q - last_q) : (last_q - first_q);
		den_zero = (den == '0);

		side_d.len       = lq_len;
		side_d.big       = lq_big;
		side_d.oor       = tag_s[LANE_LAT-1].oor;
		// A zero span only counts when the CV is actually interpolated.
		side_d.spanz     = (last_q != '0) && den_zero;
		side_d.use_first = (last_q == '0) || den_zero || (nabs == '0) || (dmag == '0);
		side_d.neg       = neg_d ^ (num[33] ^ den[33]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= lq_valid;
			v_s2   <= v_s1;
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s1 <= nabs[31:0];
		// A dummy divisor keeps the divider defined; its quotient is not used.
		emag_s1 <= den_zero ? 32'd1 : eabs[31:0];
		dmag_s1 <= dmag;
		side_s1 <= side_d;
		prod_s2 <= dmag_s1 * nmag_s1;
		emag_s2 <= emag_s1;
		side_s2 <= side_s1;
	end

	gclcv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.dividend  (prod_s2),
		.divisor   (emag_s2),
		.in_side   (side_s2),
		.out_valid (dv_valid),
		.quotient  (quot),
		.out_side  (dv_side)
	);

	// Apply the signed offset to first_cv with saturation at both ends, or pass first_cv through when use_first is set.
	always_comb begin
		if (dv_side.use_first) begin
			cv_d = first_q;
		end else if (dv_side.neg) begin
			cv_d = (quot >= {32'd0, first_q}) ? '0 : (first_q - quot[31:0]);
		end else begin
			cv_d = (quot > {32'd0, ~first_q}) ? '1 : (first_q + quot[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		result_q.length_at_age      <= dv_side.len;
		result_q.cv_at_age          <= cv_d;
		result_q.exponent_too_large <= dv_side.big;
		result_q.age_out_of_range   <= dv_side.oor;
		result_q.span_is_zero       <= dv_side.spanz;
	end

	assign done   = done_q;
	assign result = result_q;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOTAL_LAT))
		else $error("result strobe without a query at the fixed latency");

	a_zero_span_cv: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.span_is_zero) |-> (result.cv_at_age == first_q))
		else $error("zero span must return first_cv");

	a_big_exp_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.exponent_too_large) |-> (result.length_at_age == '0))
		else $error("large negative exponent must give zero length");

	a_const_cv: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (last_q == '0)) |-> ((result.cv_at_age == first_q) && !result.span_is_zero))
		else $error("constant CV mode must return first_cv without span flag");

endmodule

[sim/tb.sv]
// Self-checking testbench for the growth-curve mean length and CV block.
module tb;
	import gclcv_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int LATENCY   = TOTAL_LAT;
	localparam longint unsigned E1_Q32 = 64'd1580030169;
	localparam int CYCLE_LIMIT = 400000;

	logic          clk;
	logic          arst_n;
	logic          start = 1'b0;
	logic          busy;
	gclcv_query_t  query = '0;
	logic          done;
	gclcv_result_t result;
	logic          cfg_write;
	logic [2:0]    cfg_index;
	logic [31:0]   cfg_data;

	growth_curve_length_and_cv dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .query(query),
		.done(done), .result(result), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the configuration registers, kept in step with every write.
	logic [31:0] sh_linf, sh_k, sh_first, sh_last;
	logic signed [31:0] sh_t0;
	logic        sh_by_len;
	logic [7:0]  sh_young, sh_old;

	gclcv_query_t  pending_queries[$];
	gclcv_result_t expected_results[$];
	int  error_count = 0;
	int  cycle_count = 0;
	bit  no_idle;
	bit  hold_for_drain;
	int  idle_left = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// exp(-m) in Q1.32 for m in Q.32, by a truncated Horner series and whole powers of e^-1.
	function automatic longint unsigned exp_neg_q32(longint unsigned m);
		longint unsigned ip, f32, p;
		ip = m >> 32;
		f32 = m & 64'hFFFF_FFFF;
		p = 64'h1_0000_0000;
		if (ip >= 32)
			return 0;
		for (int n = 10; n >= 1; n--)
			p = 64'h1_0000_0000 - ((f32 * p) >> 32) / n;
		for (longint unsigned j = 0; j < ip; j++)
			p = (p * E1_Q32) >> 32;
		return p;
	endfunction

	function automatic longint unsigned length_for_age(longint unsigned age,
			longint unsigned frac, output bit big);
		longint signed x;
		longint unsigned mag, m;
		big = 1'b0;
		x = longint'(age << FRAC_BITS) + longint'(frac) - longint'(sh_t0);
		if (x == 0 || sh_k == 0)
			return 0;
		mag = (x < 0) ? longint'(-x) : x;
		if (64'(sh_k) > 64'hFFFF_FFFF_FFFF_FFFF / mag)
			m = 64'hFFFF_FFFF_FFFF_FFFF;
		else
			m = 64'(sh_k) * mag;
		if (x < 0) begin
			big = m > (64'd10 << (2 * FRAC_BITS));
			return 0;
		end
		return (64'(sh_linf) * (64'h1_0000_0000 - exp_neg_q32(m))) >> 32;
	endfunction

	// Linear interpolation of the CV with a nonzero span, saturated to 32 bits.
	function automatic longint unsigned interpolate_cv(longint signed num, longint signed den);
		bit neg_d, neg;
		longint unsigned dmag, nmag, emag, q;
		neg_d = sh_last < sh_first;
		dmag = neg_d ? 64'(sh_first - sh_last) : 64'(sh_last - sh_first);
		nmag = (num < 0) ? longint'(-num) : num;
		emag = (den < 0) ? longint'(-den) : den;
		neg = neg_d != ((num < 0) != (den < 0));
		if (nmag == 0 || dmag == 0)
			return sh_first;
		q = (dmag * nmag) / emag;
		if (neg)
			return (q >= sh_first) ? 0 : sh_first - q;
		return (q > 64'hFFFF_FFFF - sh_first) ? 64'hFFFF_FFFF : sh_first + q;
	endfunction

	function automatic gclcv_result_t predict_length_and_cv(gclcv_query_t q);
		gclcv_result_t r;
		longint unsigned age, frac, len, cv, ly, lo;
		longint signed num, den;
		bit big, unused;
		age = q.age_class;
		frac = q.step_fraction;
		len = length_for_age(age, frac, big);
		cv = sh_first;
		r.span_is_zero = 1'b0;
		if (sh_last != 0) begin
			if (sh_by_len) begin
				ly = length_for_age(sh_young, frac, unused);
				lo = length_for_age(sh_old, frac, unused);
				num = longint'(len) - longint'(ly);
				den = longint'(lo) - longint'(ly);
			end else begin
				num = longint'(age) - longint'(sh_young);
				den = longint'(sh_old) - longint'(sh_young);
			end
			if (den == 0)
				r.span_is_zero = 1'b1;
			else
				cv = interpolate_cv(num, den);
		end
		r.length_at_age = len[31:0];
		r.cv_at_age = cv[31:0];
		r.exponent_too_large = big;
		r.age_out_of_range = (q.age_class < sh_young) || (q.age_class > sh_old);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	// Driver: idles in random bursts, otherwise presents the next pending query.
	always @(negedge clk) begin
		if (!arst_n || hold_for_drain || pending_queries.size() == 0) begin
			start <= 1'b0;
		end else if (idle_left > 0) begin
			idle_left <= idle_left - 1;
			start <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			idle_left <= $urandom_range(0, 2);
			start <= 1'b0;
		end else begin
			query <= pending_queries[0];
			start <= 1'b1;
		end
	end

	// On acceptance the prediction is formed with the configuration that is live now.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_results.push_back(predict_length_and_cv(query));
			void'(pending_queries.pop_front());
		end
	end

	// Monitor: every strobed result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		gclcv_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(result.length_at_age), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (result.length_at_age !== want.length_at_age)
					report_mismatch("length_at_age", result.length_at_age, want.length_at_age);
				if (result.cv_at_age !== want.cv_at_age)
					report_mismatch("cv_at_age", result.cv_at_age, want.cv_at_age);
				if (result.exponent_too_large !== want.exponent_too_large)
					report_mismatch("exponent_too_large", result.exponent_too_large,
						want.exponent_too_large);
				if (result.age_out_of_range !== want.age_out_of_range)
					report_mismatch("age_out_of_range", result.age_out_of_range,
						want.age_out_of_range);
				if (result.span_is_zero !== want.span_is_zero)
					report_mismatch("span_is_zero", result.span_is_zero, want.span_is_zero);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("growth_curve_length_and_cv test failed");
			$finish;
		end
	end

	// Writes one register at a falling edge and updates the shadow copy.
	task automatic write_reg(gclcv_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_LINF:      sh_linf = value;
			REG_GROWTH:    sh_k = value;
			REG_T0:        sh_t0 = value;
			REG_FIRST_CV:  sh_first = value;
			REG_LAST_CV:   sh_last = value;
			REG_BY_LENGTH: sh_by_len = value[0];
			REG_YOUNGEST:  sh_young = value[7:0];
			REG_OLDEST:    sh_old = value[7:0];
			default: ;
		endcase
	endtask

	// Waits until every query has been taken and every result checked, then lets the
	// pipeline drain so that a register write cannot reach an item still in flight.
	task automatic wait_idle();
		while (pending_queries.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic add_query(logic [7:0] age, logic [15:0] frac);
		gclcv_query_t q;
		q.age_class = age;
		q.step_fraction = frac;
		pending_queries.push_back(q);
	endtask

	// Realistic random settings: a plausible curve, sometimes with extreme values.
	task automatic random_setting(int phase);
		logic [7:0] y, o;
		write_reg(REG_LINF, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF
			: $urandom_range(1, 200) << 16 | $urandom_range(0, 65535));
		write_reg(REG_GROWTH, ($urandom_range(0, 7) == 0) ? $urandom()
			: $urandom_range(0, 90000));
		write_reg(REG_T0, ($urandom_range(0, 7) == 0) ? $urandom()
			: $signed($urandom_range(0, 6 << 16)) - (3 << 16));
		write_reg(REG_FIRST_CV, ($urandom_range(0, 5) == 0) ? $urandom()
			: $urandom_range(0, 40000));
		write_reg(REG_LAST_CV, (phase % 4 == 0) ? 32'd0
			: ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(1, 40000));
		write_reg(REG_BY_LENGTH, phase % 2);
		y = 8'($urandom_range(0, 5));
		o = ($urandom_range(0, 5) == 0) ? y : 8'(y + $urandom_range(1, 30));
		if ($urandom_range(0, 7) == 0)
			o = 8'($urandom_range(0, 255));
		write_reg(REG_YOUNGEST, y);
		write_reg(REG_OLDEST, o);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_LINF;
		cfg_data = '0;
		no_idle = 1'b0;
		hold_for_drain = 1'b0;
		sh_linf = 0; sh_k = 0; sh_t0 = 0; sh_first = 0; sh_last = 0;
		sh_by_len = 1'b1; sh_young = 0; sh_old = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: zero growth gives zero length.
		add_query(8'd0, 16'd0);
		add_query(8'd255, 16'hFFFF);
		wait_idle();

		// Directed: a typical curve, interpolated by length.
		write_reg(REG_LINF, 32'd100 << 16);
		write_reg(REG_GROWTH, 32'h0000_4CCD);
		write_reg(REG_T0, -32'sd32768);
		write_reg(REG_FIRST_CV, 32'h0000_1999);
		write_reg(REG_LAST_CV, 32'h0000_3333);
		write_reg(REG_BY_LENGTH, 32'd1);
		write_reg(REG_YOUNGEST, 32'd1);
		write_reg(REG_OLDEST, 32'd20);
		add_query(8'd0, 16'd0);       // below the range, extrapolated
		add_query(8'd1, 16'd0);
		add_query(8'd10, 16'h8000);
		add_query(8'd20, 16'hFFFF);
		add_query(8'd255, 16'hFFFF);  // above the range
		add_query(8'd5, 16'h5555);
		wait_idle();

		// Directed: a large positive t0 makes the exponent huge for young ages.
		write_reg(REG_T0, 32'd50 << 16);
		write_reg(REG_GROWTH, 32'hFFFF_FFFF);
		add_query(8'd0, 16'd0);
		add_query(8'd50, 16'd0);      // exponent argument exactly zero
		add_query(8'd49, 16'hFFFF);   // just below t0
		add_query(8'd60, 16'd1);
		wait_idle();

		// Directed: age interpolation, zero span, decreasing CV, saturation, constant CV.
		write_reg(REG_T0, 32'd0);
		write_reg(REG_GROWTH, 32'd30000);
		write_reg(REG_LINF, 32'hFFFF_FFFF);
		write_reg(REG_BY_LENGTH, 32'd0);
		write_reg(REG_FIRST_CV, 32'hFFFF_0000);
		write_reg(REG_LAST_CV, 32'd100);
		add_query(8'd0, 16'd0);
		add_query(8'd30, 16'd0);
		add_query(8'd255, 16'hAAAA);  // extrapolates below zero, clamps
		wait_idle();
		write_reg(REG_FIRST_CV, 32'd100);
		write_reg(REG_LAST_CV, 32'hFFFF_FFFF);
		write_reg(REG_YOUNGEST, 32'd200);
		write_reg(REG_OLDEST, 32'd100);  // reversed range, negative span
		add_query(8'd0, 16'd0);
		add_query(8'd150, 16'd1234);
		wait_idle();
		write_reg(REG_OLDEST, 32'd200);  // zero span
		add_query(8'd7, 16'd0);
		add_query(8'd200, 16'hFFFF);
		wait_idle();
		write_reg(REG_LAST_CV, 32'd0);   // constant CV
		add_query(8'd7, 16'd0);
		add_query(8'd150, 16'h4000);
		wait_idle();

		// Random phases, each with a fresh setting and then a drain.
		for (int phase = 0; phase < 12; phase++) begin
			wait_idle();
			random_setting(phase);
			if (phase == 11)
				no_idle = 1'b1;
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 3) == 0)
					add_query(8'($urandom()), 16'($urandom()));
				else
					add_query(8'(sh_young + $urandom_range(0, 32)), 16'($urandom()));
			end
			// Once, the sender holds off in mid phase until everything has come back.
			if (phase == 5) begin
				while (pending_queries.size() > 20)
					@(posedge clk);
				hold_for_drain = 1'b1;
				while (expected_results.size() != 0)
					@(posedge clk);
				@(negedge clk);
				hold_for_drain = 1'b0;
			end
		end
		wait_idle();

		if (error_count == 0) begin
			$display("growth_curve_length_and_cv test passed");
		end else begin
			$display("growth_curve_length_and_cv test failed");
		end
		$finish;
	end

endmodule

[growth_curve_length_and_cv.f]
src/gclcv_pkg.sv
src/gclcv_exp.sv
src/gclcv_lane.sv
src/gclcv_div.sv
src/growth_curve_length_and_cv.sv
sim/tb.sv
